### hw/rtl/assert_macros.svh
// Assertion helpers for the semaphore table.
// Each macro samples on the rising edge of clk and is switched off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent holds in the same cycle as the antecedent.
`define NSEM_ASSERT_SAME(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define NSEM_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

### hw/rtl/nsem_pkg.sv
// ----------------------------------------------------------------------------
// nsem_pkg
// Shared codes, field widths and bundle types for the semaphore table.
// ----------------------------------------------------------------------------
`default_nettype none

package nsem_pkg;

    localparam int OP_W   = 3;
    localparam int SID_W  = 6;
    localparam int KEY_W  = 64;
    localparam int INIT_W = 16;
    localparam int ST_W   = 3;
    localparam int ID_W   = 5;
    localparam int VAL_W  = 16;
    localparam int REFS_W = 16;

    localparam logic [REFS_W-1:0] REFS_MAX = '1;

    typedef enum logic [OP_W-1:0] {
        OP_OPEN     = 3'd0,
        OP_CLOSE    = 3'd1,
        OP_UNLINK   = 3'd2,
        OP_TRYWAIT  = 3'd3,
        OP_POST     = 3'd4,
        OP_GETVALUE = 3'd5
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK          = 3'd0,
        ST_INVALID     = 3'd1,
        ST_NOT_FOUND   = 3'd2,
        ST_TABLE_FULL  = 3'd3,
        ST_WOULD_BLOCK = 3'd4,
        ST_OVERFLOW    = 3'd5
    } st_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_READ,
        S_MODIFY,
        S_RESP
    } state_t;

    // Write strobes towards the three entry memories.
    typedef struct packed {
        logic key_we;
        logic cnt_we;
        logic refs_we;
    } wr_en_t;

    // One result word on its way to the output register.
    typedef struct packed {
        st_t              status;
        logic [ID_W-1:0]  id;
        logic [VAL_W-1:0] value;
    } res_t;

endpackage

`default_nettype wire

### hw/rtl/nsem_ram.sv
// ----------------------------------------------------------------------------
// nsem_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module nsem_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 16,
    parameter int AW    = 5
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

### hw/rtl/nsem_ctrl.sv
// ----------------------------------------------------------------------------
// nsem_ctrl
// Request sequencer: key scan, read-modify-write of one entry, valid bits.
// ----------------------------------------------------------------------------
`default_nettype none

module nsem_ctrl #(
    parameter int SLOTS      = 32,
    parameter int COUNT_BITS = 16,
    parameter int IDX_W      = 5
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [nsem_pkg::OP_W-1:0]    opcode,
    input  wire logic                         create_flag,
    input  wire logic [nsem_pkg::KEY_W-1:0]   name_key,
    input  wire logic [nsem_pkg::INIT_W-1:0]  initial_value,
    input  wire logic [nsem_pkg::SID_W-1:0]   slot_id,
    output logic                              res_valid,
    input  wire logic                         res_take,
    output nsem_pkg::res_t                    res,
    output logic      [IDX_W-1:0]             key_rd_addr,
    input  wire logic [nsem_pkg::KEY_W-1:0]   key_rd_data,
    output logic      [IDX_W-1:0]             ent_rd_addr,
    input  wire logic [COUNT_BITS-1:0]        cnt_rd_data,
    input  wire logic [nsem_pkg::REFS_W-1:0]  refs_rd_data,
    output logic      [IDX_W-1:0]             wr_addr,
    output nsem_pkg::wr_en_t                  wr_en,
    output logic      [nsem_pkg::KEY_W-1:0]   key_wr_data,
    output logic      [COUNT_BITS-1:0]        cnt_wr_data,
    output logic      [nsem_pkg::REFS_W-1:0]  refs_wr_data
);

    localparam logic [IDX_W-1:0]      LAST_IDX = IDX_W'(SLOTS - 1);
    localparam logic [COUNT_BITS-1:0] CNT_MAX  = '1;
    localparam int CE_W = (COUNT_BITS > nsem_pkg::VAL_W) ? COUNT_BITS : nsem_pkg::VAL_W;
    localparam int IE_W = (IDX_W > nsem_pkg::ID_W) ? IDX_W : nsem_pkg::ID_W;

    nsem_pkg::state_t                 state_reg, state_next;
    logic [nsem_pkg::OP_W-1:0]        op_reg, op_next;
    logic                             create_reg, create_next;
    logic [nsem_pkg::KEY_W-1:0]       key_reg, key_next;
    logic [nsem_pkg::INIT_W-1:0]      init_reg, init_next;
    logic [IDX_W-1:0]                 scan_idx_reg, scan_idx_next;
    logic                             scan_more_reg, scan_more_next;
    logic                             chk_vld_reg, chk_vld_next;
    logic [IDX_W-1:0]                 chk_idx_reg, chk_idx_next;
    logic                             free_found_reg, free_found_next;
    logic [IDX_W-1:0]                 free_idx_reg, free_idx_next;
    logic [IDX_W-1:0]                 tgt_idx_reg, tgt_idx_next;
    logic                             hit_reg, hit_next;
    nsem_pkg::res_t                   res_reg, res_next;
    logic [SLOTS-1:0]                 valid_reg, valid_next;

    logic [IDX_W-1:0]                 sid_idx;
    logic                             sid_ok;
    logic                             hit_now;
    logic                             free_now;
    logic [CE_W-1:0]                  init_ext;
    logic                             init_big;
    logic [CE_W-1:0]                  cnt_ext;
    logic [IE_W-1:0]                  tgt_ext;
    logic [nsem_pkg::REFS_W-1:0]      refs_dec;

    assign sid_idx  = IDX_W'(slot_id);
    assign sid_ok   = (32'(slot_id) < SLOTS) && valid_reg[sid_idx];
    assign hit_now  = chk_vld_reg && valid_reg[chk_idx_reg] && (key_rd_data == key_reg);
    assign free_now = chk_vld_reg && !free_found_reg && !valid_reg[chk_idx_reg];
    assign init_ext = CE_W'(init_reg);
    assign init_big = init_ext > CE_W'(CNT_MAX);
    assign cnt_ext  = CE_W'(cnt_rd_data);
    assign tgt_ext  = IE_W'(tgt_idx_reg);
    assign refs_dec = (refs_rd_data == '0) ? '0 : refs_rd_data - 1'b1;

    assign key_rd_addr = scan_idx_reg;
    assign ent_rd_addr = tgt_idx_reg;
    assign wr_addr     = tgt_idx_reg;
    assign key_wr_data = key_reg;
    assign res         = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= nsem_pkg::S_IDLE;
            valid_reg      <= '0;
            scan_more_reg  <= 1'b0;
            chk_vld_reg    <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            valid_reg      <= valid_next;
            scan_more_reg  <= scan_more_next;
            chk_vld_reg    <= chk_vld_next;
            free_found_reg <= free_found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        create_reg   <= create_next;
        key_reg      <= key_next;
        init_reg     <= init_next;
        scan_idx_reg <= scan_idx_next;
        chk_idx_reg  <= chk_idx_next;
        free_idx_reg <= free_idx_next;
        tgt_idx_reg  <= tgt_idx_next;
        hit_reg      <= hit_next;
        res_reg      <= res_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        create_next     = create_reg;
        key_next        = key_reg;
        init_next       = init_reg;
        scan_idx_next   = scan_idx_reg;
        scan_more_next  = scan_more_reg;
        chk_vld_next    = chk_vld_reg;
        chk_idx_next    = chk_idx_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        tgt_idx_next    = tgt_idx_reg;
        hit_next        = hit_reg;
        res_next        = res_reg;
        valid_next      = valid_reg;
        wr_en           = '0;
        cnt_wr_data     = cnt_rd_data;
        refs_wr_data    = refs_rd_data;
        in_ready        = 1'b0;
        res_valid       = 1'b0;

        case (state_reg)
            nsem_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op_next         = opcode;
                    create_next     = create_flag;
                    key_next        = name_key;
                    init_next       = initial_value;
                    res_next.status = nsem_pkg::ST_OK;
                    res_next.id     = '0;
                    res_next.value  = '0;
                    scan_idx_next   = '0;
                    scan_more_next  = 1'b1;
                    chk_vld_next    = 1'b0;
                    free_found_next = 1'b0;
                    case (nsem_pkg::op_t'(opcode))
                        nsem_pkg::OP_OPEN, nsem_pkg::OP_UNLINK:
                        begin
                            state_next = nsem_pkg::S_SCAN;
                        end
                        nsem_pkg::OP_CLOSE, nsem_pkg::OP_TRYWAIT,
                        nsem_pkg::OP_POST, nsem_pkg::OP_GETVALUE:
                        begin
                            if (sid_ok)
                            begin
                                tgt_idx_next = sid_idx;
                                hit_next     = 1'b1;
                                state_next   = nsem_pkg::S_READ;
                            end
                            else
                            begin
                                res_next.status = nsem_pkg::ST_INVALID;
                                state_next      = nsem_pkg::S_RESP;
                            end
                        end
                        default:
                        begin
                            res_next.status = nsem_pkg::ST_INVALID;
                            state_next      = nsem_pkg::S_RESP;
                        end
                    endcase
                end
            end

            nsem_pkg::S_SCAN:
            begin
                // issue one key read a cycle, check the word read the cycle before
                chk_vld_next = scan_more_reg;
                chk_idx_next = scan_idx_reg;
                if (scan_more_reg)
                begin
                    if (scan_idx_reg == LAST_IDX)
                    begin
                        scan_more_next = 1'b0;
                    end
                    else
                    begin
                        scan_idx_next = scan_idx_reg + 1'b1;
                    end
                end
                if (hit_now)
                begin
                    tgt_idx_next = chk_idx_reg;
                    hit_next     = 1'b1;
                    state_next   = nsem_pkg::S_READ;
                end
                else if (chk_vld_reg)
                begin
                    if (free_now)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = chk_idx_reg;
                    end
                    if (chk_idx_reg == LAST_IDX)
                    begin
                        if ((op_reg == nsem_pkg::OP_UNLINK) || !create_reg)
                        begin
                            res_next.status = nsem_pkg::ST_NOT_FOUND;
                            state_next      = nsem_pkg::S_RESP;
                        end
                        else if (free_found_reg || free_now)
                        begin
                            tgt_idx_next = free_found_reg ? free_idx_reg : chk_idx_reg;
                            hit_next     = 1'b0;
                            state_next   = nsem_pkg::S_MODIFY;
                        end
                        else
                        begin
                            res_next.status = nsem_pkg::ST_TABLE_FULL;
                            state_next      = nsem_pkg::S_RESP;
                        end
                    end
                end
            end

            nsem_pkg::S_READ:
            begin
                state_next = nsem_pkg::S_MODIFY;
            end

            nsem_pkg::S_MODIFY:
            begin
                state_next = nsem_pkg::S_RESP;
                case (nsem_pkg::op_t'(op_reg))
                    nsem_pkg::OP_OPEN:
                    begin
                        res_next.id = tgt_ext[nsem_pkg::ID_W-1:0];
                        if (hit_reg)
                        begin
                            if (refs_rd_data == nsem_pkg::REFS_MAX)
                            begin
                                res_next.status = nsem_pkg::ST_OVERFLOW;
                            end
                            else
                            begin
                                refs_wr_data  = refs_rd_data + 1'b1;
                                wr_en.refs_we = 1'b1;
                            end
                        end
                        else
                        begin
                            wr_en.key_we  = 1'b1;
                            wr_en.cnt_we  = 1'b1;
                            wr_en.refs_we = 1'b1;
                            refs_wr_data  = nsem_pkg::REFS_W'(1);
                            cnt_wr_data   = init_big ? CNT_MAX : COUNT_BITS'(init_reg);
                            valid_next[tgt_idx_reg] = 1'b1;
                            if (init_big)
                            begin
                                res_next.status = nsem_pkg::ST_OVERFLOW;
                            end
                        end
                    end
                    nsem_pkg::OP_CLOSE, nsem_pkg::OP_UNLINK:
                    begin
                        if (refs_dec == '0)
                        begin
                            valid_next[tgt_idx_reg] = 1'b0;
                        end
                        else
                        begin
                            refs_wr_data  = refs_dec;
                            wr_en.refs_we = 1'b1;
                        end
                    end
                    nsem_pkg::OP_TRYWAIT:
                    begin
                        if (cnt_rd_data == '0)
                        begin
                            res_next.status = nsem_pkg::ST_WOULD_BLOCK;
                        end
                        else
                        begin
                            cnt_wr_data  = cnt_rd_data - 1'b1;
                            wr_en.cnt_we = 1'b1;
                        end
                    end
                    nsem_pkg::OP_POST:
                    begin
                        if (cnt_rd_data == CNT_MAX)
                        begin
                            res_next.status = nsem_pkg::ST_OVERFLOW;
                        end
                        else
                        begin
                            cnt_wr_data  = cnt_rd_data + 1'b1;
                            wr_en.cnt_we = 1'b1;
                        end
                    end
                    nsem_pkg::OP_GETVALUE:
                    begin
                        if (cnt_ext > CE_W'({nsem_pkg::VAL_W{1'b1}}))
                        begin
                            res_next.value = '1;
                        end
                        else
                        begin
                            res_next.value = cnt_ext[nsem_pkg::VAL_W-1:0];
                        end
                    end
                    default:
                    begin
                        res_next.status = nsem_pkg::ST_INVALID;
                    end
                endcase
            end

            nsem_pkg::S_RESP:
            begin
                res_valid = 1'b1;
                if (res_take)
                begin
                    state_next = nsem_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = nsem_pkg::S_IDLE;
            end
        endcase
    end

`include "assert_macros.svh"

    `NSEM_ASSERT_NEXT(a_accept_leaves_idle, in_valid && in_ready, state_reg != nsem_pkg::S_IDLE, "accepted word did not start a request")
    `NSEM_ASSERT_NEXT(a_hit_targets_entry, state_reg == nsem_pkg::S_SCAN && hit_now, state_reg == nsem_pkg::S_READ && tgt_idx_reg == $past(chk_idx_reg), "key match not taken as target")
    `NSEM_ASSERT_NEXT(a_create_sets_valid, state_reg == nsem_pkg::S_MODIFY && op_reg == nsem_pkg::OP_OPEN && !hit_reg, valid_reg[$past(tgt_idx_reg)], "created entry not marked valid")
    `NSEM_ASSERT_SAME(a_write_in_modify, wr_en.key_we || wr_en.cnt_we || wr_en.refs_we, state_reg == nsem_pkg::S_MODIFY, "entry memory written outside modify")

endmodule

`default_nettype wire

### hw/rtl/named_counting_semaphore_table.sv
// Timing: getvalue, trywait, post and close on a good id pass through the read, modify
// and response states; bad ids and unknown opcodes go straight to the response state;
// open and unlink first scan the keys (one slot a cycle). One request is in flight at a
// time: in_ready rises again the cycle after the result enters the output register.
// Reset: asynchronous, active low; clears every valid bit at once, no clearing pass.
// ----------------------------------------------------------------------------
// named_counting_semaphore_table
// Table of counting semaphores looked up by a 64-bit name key or by slot id.
// ----------------------------------------------------------------------------
`default_nettype none

module named_counting_semaphore_table #(
    parameter int SLOTS      = 32,
    parameter int COUNT_BITS = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [nsem_pkg::OP_W-1:0]     opcode,
    input  wire logic                          create_flag,
    input  wire logic [nsem_pkg::KEY_W-1:0]    name_key,
    input  wire logic [nsem_pkg::INIT_W-1:0]   initial_value,
    input  wire logic [nsem_pkg::SID_W-1:0]    slot_id,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic      [nsem_pkg::ST_W-1:0]     status,
    output logic      [nsem_pkg::ID_W-1:0]     id_out,
    output logic      [nsem_pkg::VAL_W-1:0]    value_out
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // Entry state is split over three memories (key, count, reference count),
    // each with one write port and a registered read port. The valid bits live
    // in flip-flops inside the sequencer so reset can clear them in one go.
    // Only one request is ever in flight, so a write-back in the modify cycle
    // can never race a later read of the same entry: the sequencer itself is
    // the interlock.

    logic [IDX_W-1:0]                 key_rd_addr;
    logic [nsem_pkg::KEY_W-1:0]       key_rd_data;
    logic [IDX_W-1:0]                 ent_rd_addr;
    logic [COUNT_BITS-1:0]            cnt_rd_data;
    logic [nsem_pkg::REFS_W-1:0]      refs_rd_data;
    logic [IDX_W-1:0]                 wr_addr;
    nsem_pkg::wr_en_t                 wr_en;
    logic [nsem_pkg::KEY_W-1:0]       key_wr_data;
    logic [COUNT_BITS-1:0]            cnt_wr_data;
    logic [nsem_pkg::REFS_W-1:0]      refs_wr_data;

    logic                             res_valid;
    logic                             res_take;
    nsem_pkg::res_t                   res;

    logic                             out_valid_reg, out_valid_next;
    nsem_pkg::res_t                   out_res_reg;

    // Request sequencer: scans keys for open and unlink, then reads, modifies
    // and writes back the one entry the request concerns.
    nsem_ctrl #(
        .SLOTS      (SLOTS),
        .COUNT_BITS (COUNT_BITS),
        .IDX_W      (IDX_W)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .opcode        (opcode),
        .create_flag   (create_flag),
        .name_key      (name_key),
        .initial_value (initial_value),
        .slot_id       (slot_id),
        .res_valid     (res_valid),
        .res_take      (res_take),
        .res           (res),
        .key_rd_addr   (key_rd_addr),
        .key_rd_data   (key_rd_data),
        .ent_rd_addr   (ent_rd_addr),
        .cnt_rd_data   (cnt_rd_data),
        .refs_rd_data  (refs_rd_data),
        .wr_addr       (wr_addr),
        .wr_en         (wr_en),
        .key_wr_data   (key_wr_data),
        .cnt_wr_data   (cnt_wr_data),
        .refs_wr_data  (refs_wr_data)
    );

    // Name keys: read by the scan, written when open creates an entry.
    nsem_ram #(
        .DEPTH (SLOTS),
        .WIDTH (nsem_pkg::KEY_W),
        .AW    (IDX_W)
    ) u_key_ram (
        .clk     (clk),
        .we      (wr_en.key_we),
        .wr_addr (wr_addr),
        .wr_data (key_wr_data),
        .rd_addr (key_rd_addr),
        .rd_data (key_rd_data)
    );

    // Semaphore counts.
    nsem_ram #(
        .DEPTH (SLOTS),
        .WIDTH (COUNT_BITS),
        .AW    (IDX_W)
    ) u_cnt_ram (
        .clk     (clk),
        .we      (wr_en.cnt_we),
        .wr_addr (wr_addr),
        .wr_data (cnt_wr_data),
        .rd_addr (ent_rd_addr),
        .rd_data (cnt_rd_data)
    );

    // Reference counts.
    nsem_ram #(
        .DEPTH (SLOTS),
        .WIDTH (nsem_pkg::REFS_W),
        .AW    (IDX_W)
    ) u_refs_ram (
        .clk     (clk),
        .we      (wr_en.refs_we),
        .wr_addr (wr_addr),
        .wr_data (refs_wr_data),
        .rd_addr (ent_rd_addr),
        .rd_data (refs_rd_data)
    );

    // Output register: hold the result word until the consumer takes it, and
    // let the sequencer drop its next result in as the current one leaves.
    assign res_take = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid && res_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload: no reset, loaded only alongside the valid flag.
    always_ff @(posedge clk)
    begin
        if (res_valid && res_take)
        begin
            out_res_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = out_res_reg.status;
    assign id_out    = out_res_reg.id;
    assign value_out = out_res_reg.value;

endmodule

`default_nettype wire

### tb/named_counting_semaphore_table_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// named_counting_semaphore_table_tb
// Drives request words into the semaphore table and checks every result word
// against a shadow copy of the table kept inside the testbench. The run has
// three parts: a directed pass over the corner cases, a pass that fills the
// table and empties it again, and a random mix with gaps on both sides.
// ----------------------------------------------------------------------------
`default_nettype none

module named_counting_semaphore_table_tb;

    localparam int SEM_SLOTS    = 32;
    localparam int COUNT_W      = 16;
    localparam longint unsigned COUNT_MAX = (64'd1 << COUNT_W) - 1;

    // Opcodes the block does not define; both must answer invalid.
    localparam logic [nsem_pkg::OP_W-1:0] OP_RSVD6 = 3'd6;
    localparam logic [nsem_pkg::OP_W-1:0] OP_RSVD7 = 3'd7;

    localparam int RANDOM_WORDS = 560;
    localparam int POOL_KEYS    = 40;
    // The longest open/unlink is a full key scan; leave a margin on top.
    localparam int SETTLE_CYCLES = SEM_SLOTS + 12;

    localparam logic [nsem_pkg::KEY_W-1:0] HELD_KEY = 64'h0123_4567_89AB_CDEF;

    // ------------------------------------------------------------------------
    // Shadow of the semaphore table and the queue of answers still owed.
    // ------------------------------------------------------------------------
    class semaphore_shadow;
        bit                            live      [SEM_SLOTS];
        logic [nsem_pkg::KEY_W-1:0]    slot_name [SEM_SLOTS];
        logic [COUNT_W-1:0]            count     [SEM_SLOTS];
        logic [nsem_pkg::REFS_W-1:0]   refs      [SEM_SLOTS];
        nsem_pkg::res_t                owed_answers [$];
        int unsigned                   mismatches;

        function void clear_entry(int i);
            live[i]      = 1'b0;
            slot_name[i] = '0;
            count[i]     = '0;
            refs[i]      = '0;
        endfunction

        function new();
            for (int i = 0; i < SEM_SLOTS; i++)
                clear_entry(i);
            mismatches = 0;
        endfunction

        function int lookup(logic [nsem_pkg::KEY_W-1:0] key);
            for (int i = 0; i < SEM_SLOTS; i++)
                if (live[i] && slot_name[i] == key)
                    return i;
            return -1;
        endfunction

        function void drop_ref(int i);
            if (refs[i] != 0)
                refs[i]--;
            if (refs[i] == 0)
                clear_entry(i);
        endfunction

        function int outstanding();
            return owed_answers.size();
        endfunction

        // Index of some live entry, so that most id-based requests land.
        function int some_live_slot();
            int picks [$];
            for (int i = 0; i < SEM_SLOTS; i++)
                if (live[i])
                    picks.push_back(i);
            if (picks.size() == 0)
                return $urandom_range(0, 63);
            return picks[$urandom_range(0, picks.size() - 1)];
        endfunction

        // Apply one accepted request to the shadow and queue its answer.
        function void note_request(logic [nsem_pkg::OP_W-1:0] op, logic create,
                                   logic [nsem_pkg::KEY_W-1:0] key,
                                   logic [nsem_pkg::INIT_W-1:0] init,
                                   logic [nsem_pkg::SID_W-1:0] sid);
            nsem_pkg::res_t ans;
            int             hit;
            ans.status = nsem_pkg::ST_OK;
            ans.id     = '0;
            ans.value  = '0;
            case (op)
                nsem_pkg::OP_OPEN: begin
                    hit = lookup(key);
                    if (hit >= 0) begin
                        if (refs[hit] == nsem_pkg::REFS_MAX)
                            ans.status = nsem_pkg::ST_OVERFLOW;
                        else
                            refs[hit]++;
                        ans.id = hit[nsem_pkg::ID_W-1:0];
                    end else if (!create) begin
                        ans.status = nsem_pkg::ST_NOT_FOUND;
                    end else begin
                        for (int i = SEM_SLOTS - 1; i >= 0; i--)
                            if (!live[i])
                                hit = i;
                        if (hit < 0) begin
                            ans.status = nsem_pkg::ST_TABLE_FULL;
                        end else begin
                            live[hit]      = 1'b1;
                            slot_name[hit] = key;
                            refs[hit]      = nsem_pkg::REFS_W'(1);
                            if (64'(init) > COUNT_MAX) begin
                                count[hit] = COUNT_MAX[COUNT_W-1:0];
                                ans.status = nsem_pkg::ST_OVERFLOW;
                            end else begin
                                count[hit] = COUNT_W'(init);
                            end
                            ans.id = hit[nsem_pkg::ID_W-1:0];
                        end
                    end
                end
                nsem_pkg::OP_UNLINK: begin
                    hit = lookup(key);
                    if (hit >= 0)
                        drop_ref(hit);
                    else
                        ans.status = nsem_pkg::ST_NOT_FOUND;
                end
                nsem_pkg::OP_CLOSE, nsem_pkg::OP_TRYWAIT,
                nsem_pkg::OP_POST, nsem_pkg::OP_GETVALUE: begin
                    if (sid >= SEM_SLOTS || !live[sid]) begin
                        ans.status = nsem_pkg::ST_INVALID;
                    end else begin
                        case (op)
                            nsem_pkg::OP_CLOSE: drop_ref(sid);
                            nsem_pkg::OP_TRYWAIT: begin
                                if (count[sid] != 0)
                                    count[sid]--;
                                else
                                    ans.status = nsem_pkg::ST_WOULD_BLOCK;
                            end
                            nsem_pkg::OP_POST: begin
                                if (64'(count[sid]) >= COUNT_MAX)
                                    ans.status = nsem_pkg::ST_OVERFLOW;
                                else
                                    count[sid]++;
                            end
                            default: begin
                                if (64'(count[sid]) > 64'hFFFF)
                                    ans.value = '1;
                                else
                                    ans.value = nsem_pkg::VAL_W'(count[sid]);
                            end
                        endcase
                    end
                end
                default: ans.status = nsem_pkg::ST_INVALID;
            endcase
            owed_answers.push_back(ans);
        endfunction

        // Compare one result word with the oldest answer owed.
        function void check_answer(logic [nsem_pkg::ST_W-1:0] st,
                                   logic [nsem_pkg::ID_W-1:0] id,
                                   logic [nsem_pkg::VAL_W-1:0] val);
            nsem_pkg::res_t want;
            if (owed_answers.size() == 0) begin
                mismatches++;
                $display("%0t: result word with nothing owed: expected none, got %0d/%0d/%0d",
                         $time, st, id, val);
                return;
            end
            want = owed_answers.pop_front();
            if (st !== want.status) begin
                mismatches++;
                $display("%0t: status expected %0d, got %0d", $time, want.status, st);
            end
            if (id !== want.id) begin
                mismatches++;
                $display("%0t: id_out expected %0d, got %0d", $time, want.id, id);
            end
            if (val !== want.value) begin
                mismatches++;
                $display("%0t: value_out expected %0d, got %0d", $time, want.value, val);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals towards the block
    // ------------------------------------------------------------------------
    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_ready;
    logic [nsem_pkg::OP_W-1:0]     opcode;
    logic                          create_flag;
    logic [nsem_pkg::KEY_W-1:0]    name_key;
    logic [nsem_pkg::INIT_W-1:0]   initial_value;
    logic [nsem_pkg::SID_W-1:0]    slot_id;
    logic                          out_valid;
    logic                          out_ready;
    logic [nsem_pkg::ST_W-1:0]     status;
    logic [nsem_pkg::ID_W-1:0]     id_out;
    logic [nsem_pkg::VAL_W-1:0]    value_out;

    semaphore_shadow               sem_shadow;
    bit                            idle_on;      // gaps and stalls allowed on both sides
    int                            stall_left;
    logic [nsem_pkg::KEY_W-1:0]    key_pool  [POOL_KEYS];
    logic [nsem_pkg::KEY_W-1:0]    fill_keys [SEM_SLOTS + 1];

    named_counting_semaphore_table #(
        .SLOTS      (SEM_SLOTS),
        .COUNT_BITS (COUNT_W)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .opcode        (opcode),
        .create_flag   (create_flag),
        .name_key      (name_key),
        .initial_value (initial_value),
        .slot_id       (slot_id),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .id_out        (id_out),
        .value_out     (value_out)
    );

    // 2 ns clock.
    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Gap length: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [nsem_pkg::KEY_W-1:0] any_key();
        return {$urandom, $urandom};
    endfunction

    // ------------------------------------------------------------------------
    // Result side: check each accepted word, then pick the next ready level.
    // Sample before this edge's updates land, so the values seen are the ones
    // the handshake used.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (out_valid && out_ready)
                sem_shadow.check_answer(status, id_out, value_out);
            if (stall_left > 0) begin
                stall_left--;
                out_ready <= 1'b0;
            end else if (idle_on) begin
                stall_left = pick_gap();
                out_ready <= (stall_left == 0);
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Request side. Entered at a rising edge; leaves at the edge where the
    // word was taken, with valid still high so that a back-to-back word
    // needs no drop in between.
    // ------------------------------------------------------------------------
    task automatic send_request(input logic [nsem_pkg::OP_W-1:0] op, input logic create,
                                input logic [nsem_pkg::KEY_W-1:0] key,
                                input logic [nsem_pkg::INIT_W-1:0] init,
                                input logic [nsem_pkg::SID_W-1:0] sid);
        int gap;
        gap = idle_on ? pick_gap() : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        opcode        <= op;
        create_flag   <= create;
        name_key      <= key;
        initial_value <= init;
        slot_id       <= sid;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sem_shadow.note_request(op, create, key, init, sid);
    endtask

    // Hold the sender off until every owed answer has come back. Always
    // advance at least one edge, so valid is never dropped and raised in
    // one step.
    task automatic wait_for_answers();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sem_shadow.outstanding() != 0)
            @(posedge clk);
    endtask

    // One random word: mostly opens and id requests aimed at live entries,
    // with stray keys, bad ids and undefined opcodes mixed in.
    task automatic send_random_word();
        int                            r;
        logic [nsem_pkg::OP_W-1:0]     op;
        logic                          create;
        logic [nsem_pkg::KEY_W-1:0]    key;
        logic [nsem_pkg::INIT_W-1:0]   init;
        logic [nsem_pkg::SID_W-1:0]    sid;
        r      = $urandom_range(0, 99);
        create = ($urandom_range(0, 9) < 8);
        key    = ($urandom_range(0, 9) == 0) ? any_key()
                                             : key_pool[$urandom_range(0, POOL_KEYS - 1)];
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: init = nsem_pkg::INIT_W'($urandom_range(0, 3));
            9:             init = $urandom_range(0, 1) ? '1 : '0;
            default:       init = nsem_pkg::INIT_W'($urandom);
        endcase
        sid = ($urandom_range(0, 6) == 0) ? nsem_pkg::SID_W'($urandom_range(0, 63))
                                          : nsem_pkg::SID_W'(sem_shadow.some_live_slot());
        if (r < 24)
            op = nsem_pkg::OP_OPEN;
        else if (r < 38)
            op = nsem_pkg::OP_UNLINK;
        else if (r < 50)
            op = nsem_pkg::OP_CLOSE;
        else if (r < 64)
            op = nsem_pkg::OP_TRYWAIT;
        else if (r < 78)
            op = nsem_pkg::OP_POST;
        else if (r < 93)
            op = nsem_pkg::OP_GETVALUE;
        else
            op = $urandom_range(0, 1) ? OP_RSVD6 : OP_RSVD7;
        send_request(op, create, key, init, sid);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        opcode        = '0;
        create_flag   = 1'b0;
        name_key      = '0;
        initial_value = '0;
        slot_id       = '0;
        out_ready     = 1'b0;
        idle_on       = 1'b1;
        stall_left    = 0;
        sem_shadow    = new();

        key_pool[0] = HELD_KEY;
        key_pool[1] = '0;
        key_pool[2] = '1;
        for (int i = 3; i < POOL_KEYS; i++)
            key_pool[i] = any_key();
        for (int i = 0; i <= SEM_SLOTS; i++)
            fill_keys[i] = any_key();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed corners on an empty table: bad ids, undefined opcodes,
        // missing keys, saturated count, empty count, reopen and teardown.
        send_request(nsem_pkg::OP_GETVALUE, 1'b0, '0, '0, 6'd0);
        send_request(nsem_pkg::OP_CLOSE,    1'b0, '0, '0, 6'd63);
        send_request(OP_RSVD6,              1'b1, '1, '1, 6'd5);
        send_request(OP_RSVD7,              1'b0, '0, '0, 6'd0);
        send_request(nsem_pkg::OP_OPEN,     1'b0, '0, '0, 6'd0);
        send_request(nsem_pkg::OP_UNLINK,   1'b0, '1, '0, 6'd0);
        send_request(nsem_pkg::OP_OPEN,     1'b1, '1, 16'hFFFF, 6'd0);
        send_request(nsem_pkg::OP_POST,     1'b0, '0, '0, 6'd0);
        send_request(nsem_pkg::OP_GETVALUE, 1'b0, '0, '0, 6'd0);
        send_request(nsem_pkg::OP_OPEN,     1'b1, '0, 16'h0000, 6'd0);
        send_request(nsem_pkg::OP_TRYWAIT,  1'b0, '0, '0, 6'd1);
        send_request(nsem_pkg::OP_POST,     1'b0, '0, '0, 6'd1);
        send_request(nsem_pkg::OP_TRYWAIT,  1'b0, '0, '0, 6'd1);
        send_request(nsem_pkg::OP_GETVALUE, 1'b0, '0, '0, 6'd1);
        send_request(nsem_pkg::OP_OPEN,     1'b0, '0, '0, 6'd0);
        send_request(nsem_pkg::OP_UNLINK,   1'b0, '0, '0, 6'd0);
        send_request(nsem_pkg::OP_CLOSE,    1'b0, '0, '0, 6'd1);
        send_request(nsem_pkg::OP_GETVALUE, 1'b0, '0, '0, 6'd1);
        send_request(nsem_pkg::OP_TRYWAIT,  1'b0, '0, '0, 6'd32);
        send_request(nsem_pkg::OP_UNLINK,   1'b0, '1, '0, 6'd0);
        send_request(nsem_pkg::OP_OPEN,     1'b1, 64'h5555_AAAA_5555_AAAA, 16'hA5A5, 6'd0);
        send_request(nsem_pkg::OP_POST,     1'b0, '0, '0, 6'd31);
        wait_for_answers();

        // Fill every slot, push two more creates into a full table, then
        // unlink the lot so the table is empty again.
        for (int i = 0; i <= SEM_SLOTS; i++)
            send_request(nsem_pkg::OP_OPEN, 1'b1, fill_keys[i], 16'(i), 6'(i));
        for (int i = 0; i <= SEM_SLOTS; i++)
            send_request(nsem_pkg::OP_UNLINK, 1'b0, fill_keys[i], '0, '0);
        send_request(nsem_pkg::OP_UNLINK, 1'b0, 64'h5555_AAAA_5555_AAAA, '0, '0);
        wait_for_answers();

        // Random mix. Every fourth stretch runs without gaps or stalls, and
        // every so often the sender waits for the table to go quiet.
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            idle_on = ((n / 100) % 4) != 3;
            if (n % 200 == 199)
                wait_for_answers();
            send_random_word();
        end

        wait_for_answers();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sem_shadow.mismatches == 0)
            $display("named_counting_semaphore_table_tb: done, clean");
        else
            $display("named_counting_semaphore_table_tb: done, errors");
        $finish;
    end

    // Watchdog. About 650 words, each at worst a long gap, a full key scan and a long
    // stall, come to well under 0.2 ms; 2 ms is ample.
    initial
    begin
        #2_000_000;
        $display("named_counting_semaphore_table_tb: done, errors");
        $finish;
    end

endmodule

`default_nettype wire
